@@ sv/hvd_pkg.sv @@
// Package with the shared types and fixed constants of the haversine distance pipeline.
`default_nettype none
package hvd_pkg;

  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 32;
  localparam int SQRT_STEPS   = 31;
  localparam int LANES        = 4;
  localparam int LATENCY      = 7 + CORDIC_STEPS + 4 + SQRT_STEPS + 1 + CORDIC_STEPS + 5;

  typedef logic signed [ANGLE_BITS+1:0] cw_t;
  typedef logic signed [31:0]           q30_t;

  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;

  localparam logic [22:0] RADIUS_RST = 23'd6371000;

  localparam logic [33:0] RECIP = 34'd10248191152;
  localparam logic [56:0] DR     = 57'd36028797018750000;
  localparam logic [21:0] DVAL   = 22'd3515625;
  localparam logic [22:0] EVAL   = 23'd7031250;

  localparam cw_t  GAIN    = 34'sd652032874;
  localparam cw_t  QUARTER = 34'sd1073741824;
  localparam cw_t  HALF    = 34'sd2147483648;
  localparam q30_t ONE_Q   = 32'sd1073741824;

  localparam logic [71:0] DIST_K = 72'h6487ED5110B4611A * 72'd400;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage
`default_nettype wire

@@ sv/haversine_distance_top.sv @@
// Top level of the pipelined fixed-point haversine great-circle distance block.
//
// One request on the in_ channel carries two points (latitude and longitude in
// 1e-7 degree); one request on the out_ channel returns the distance in cm.
// The cfg_ channel writes the sphere radius in metres; it is always ready and
// should be written only while the pipeline holds no requests.
// The pipeline has 112 register stages. Most of the depth comes from two
// unrolled 32-step CORDIC chains and the two parallel 31-step square root
// chains, each step its own register stage.
// Throughput is one request per cycle while the output is not stalled.
// Reset clears all valid bits and loads a radius of 6371000 m.
// When the output holds a request that is not taken, the whole pipeline
// freezes and in_ready drops; nothing is dropped or duplicated, and in_ready
// returns in the same cycle out_ready is seen.
`default_nettype none
module haversine_distance_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] in_start_latitude,
  input  wire logic signed [31:0] in_start_longitude,
  input  wire logic signed [30:0] in_end_latitude,
  input  wire logic signed [31:0] in_end_longitude,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [22:0]        cfg_sphere_radius_m,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_distance_cm
);

  localparam int NL = hvd_pkg::LANES;
  localparam int NC = hvd_pkg::CORDIC_STEPS;
  localparam int NS = hvd_pkg::SQRT_STEPS;
  localparam int LAT = hvd_pkg::LATENCY;

  function automatic hvd_pkg::q30_t mul_q(input hvd_pkg::q30_t a, input hvd_pkg::q30_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  logic adv;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [22:0] radius_r, radius_nxt;

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};
  assign radius_nxt = cfg_valid ? cfg_sphere_radius_m : radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= hvd_pkg::RADIUS_RST;
    end else begin
      radius_r <= radius_nxt;
      if (adv) begin
        vld_r <= vld_nxt;
      end
    end
  end

  // Input stage: saturate coordinates, form differences and magnitudes.
  logic signed [30:0] lat1_c, lat2_c;
  logic signed [31:0] lon1_c, lon2_c;
  logic signed [32:0] sv_val [NL];

  assign lat1_c = (in_start_latitude > hvd_pkg::LAT_MAX) ? hvd_pkg::LAT_MAX :
                  (in_start_latitude < -hvd_pkg::LAT_MAX) ? -hvd_pkg::LAT_MAX : in_start_latitude;
  assign lat2_c = (in_end_latitude > hvd_pkg::LAT_MAX) ? hvd_pkg::LAT_MAX :
                  (in_end_latitude < -hvd_pkg::LAT_MAX) ? -hvd_pkg::LAT_MAX : in_end_latitude;
  assign lon1_c = (in_start_longitude > hvd_pkg::LON_MAX) ? hvd_pkg::LON_MAX :
                  (in_start_longitude < -hvd_pkg::LON_MAX) ? -hvd_pkg::LON_MAX :
                  in_start_longitude;
  assign lon2_c = (in_end_longitude > hvd_pkg::LON_MAX) ? hvd_pkg::LON_MAX :
                  (in_end_longitude < -hvd_pkg::LON_MAX) ? -hvd_pkg::LON_MAX :
                  in_end_longitude;

  assign sv_val[0] = 33'(lat1_c);
  assign sv_val[1] = 33'(lat2_c);
  assign sv_val[2] = 33'(lat2_c) - 33'(lat1_c);
  assign sv_val[3] = 33'(lon2_c) - 33'(lon1_c);

  logic [31:0] mag_r   [NL];
  logic        neg_r   [NL][5];
  logic [48:0] pph_r   [NL];
  logic [48:0] ppl_r   [NL];
  logic [24:0] xlow_r  [NL][4];
  logic [65:0] p_r     [NL];
  logic [32:0] qe_r    [NL][2];
  logic [24:0] prod_r  [NL];
  hvd_pkg::cw_t th_r   [NL];

  hvd_pkg::cw_t cx_r [NL][NC+1];
  hvd_pkg::cw_t cy_r [NL][NC+1];
  hvd_pkg::cw_t cz_r [NL][NC+1];
  logic         cflip_r [NL][NC+1];
  hvd_pkg::q30_t trig_r [NL];

  for (genvar l = 0; l < NL; l++) begin : g_conv
    localparam int KSH = (l < 2) ? 23 : 22;
    logic signed [32:0] abs_v;
    logic [89:0]        t_sum;
    logic [24:0]        rem;
    logic [32:0]        q_fix;
    hvd_pkg::cw_t       th_fold;
    logic               fold_hi, fold_lo;

    assign abs_v   = sv_val[l][32] ? -sv_val[l] : sv_val[l];
    assign t_sum   = (90'(p_r[l]) << KSH) + 90'(hvd_pkg::DR);
    assign rem     = xlow_r[l][3] - prod_r[l];
    assign q_fix   = qe_r[l][1] + 33'(rem >= 25'(hvd_pkg::EVAL));
    assign fold_hi = th_r[l] > hvd_pkg::QUARTER;
    assign fold_lo = th_r[l] < -hvd_pkg::QUARTER;
    assign th_fold = fold_hi ? th_r[l] - hvd_pkg::HALF :
                     fold_lo ? th_r[l] + hvd_pkg::HALF : th_r[l];

    always_ff @(posedge clk) begin
      if (adv) begin
        mag_r[l]     <= abs_v[31:0];
        neg_r[l][0]  <= sv_val[l][32];
        pph_r[l]     <= 49'(mag_r[l]) * 49'(hvd_pkg::RECIP[33:17]);
        ppl_r[l]     <= 49'(mag_r[l]) * 49'(hvd_pkg::RECIP[16:0]);
        xlow_r[l][0] <= (25'(mag_r[l]) << KSH) + 25'(hvd_pkg::DVAL);
        neg_r[l][1]  <= neg_r[l][0];
        p_r[l]       <= {pph_r[l], 17'd0} + 66'(ppl_r[l]);
        xlow_r[l][1] <= xlow_r[l][0];
        neg_r[l][2]  <= neg_r[l][1];
        qe_r[l][0]   <= t_sum[88:56];
        xlow_r[l][2] <= xlow_r[l][1];
        neg_r[l][3]  <= neg_r[l][2];
        prod_r[l]    <= qe_r[l][0][24:0] * 25'(hvd_pkg::EVAL);
        qe_r[l][1]   <= qe_r[l][0];
        xlow_r[l][3] <= xlow_r[l][2];
        neg_r[l][4]  <= neg_r[l][3];
        th_r[l]      <= neg_r[l][4] ? -$signed(34'(q_fix)) : $signed(34'(q_fix));
        cx_r[l][0]   <= hvd_pkg::GAIN;
        cy_r[l][0]   <= '0;
        cz_r[l][0]   <= th_fold;
        cflip_r[l][0] <= fold_hi || fold_lo;
      end
    end

    for (genvar i = 0; i < NC; i++) begin : g_rot
      hvd_pkg::cw_t xs, ys, at;
      assign xs = cx_r[l][i] >>> i;
      assign ys = cy_r[l][i] >>> i;
      assign at = $signed(34'(hvd_pkg::ATAN_TURN[i]));
      always_ff @(posedge clk) begin
        if (adv) begin
          cflip_r[l][i+1] <= cflip_r[l][i];
          if (!cz_r[l][i][33]) begin
            cx_r[l][i+1] <= cx_r[l][i] - ys;
            cy_r[l][i+1] <= cy_r[l][i] + xs;
            cz_r[l][i+1] <= cz_r[l][i] - at;
          end else begin
            cx_r[l][i+1] <= cx_r[l][i] + ys;
            cy_r[l][i+1] <= cy_r[l][i] - xs;
            cz_r[l][i+1] <= cz_r[l][i] + at;
          end
        end
      end
    end

    hvd_pkg::cw_t sel_v, sel_f;
    assign sel_v = (l < 2) ? cx_r[l][NC] : cy_r[l][NC];
    assign sel_f = cflip_r[l][NC] ? -sel_v : sel_v;

    always_ff @(posedge clk) begin
      if (adv) begin
        trig_r[l] <= (sel_f > 34'(hvd_pkg::ONE_Q)) ? hvd_pkg::ONE_Q :
                     (sel_f < -34'(hvd_pkg::ONE_Q)) ? -hvd_pkg::ONE_Q : 32'(sel_f);
      end
    end
  end

  // Haversine term: trig_r holds cos(lat1), cos(lat2), sin(dlat/2), sin(dlon/2).
  hvd_pkg::q30_t sqlat_r, sqlat2_r, c12_r, sqlon_r, t_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sqlat_r  <= mul_q(trig_r[2], trig_r[2]);
      c12_r    <= mul_q(trig_r[0], trig_r[1]);
      sqlon_r  <= mul_q(trig_r[3], trig_r[3]);
      sqlat2_r <= sqlat_r;
      t_r      <= mul_q(c12_r, sqlon_r);
    end
  end

  logic signed [32:0] a_sum;
  logic [30:0]        a_c;
  assign a_sum = 33'(sqlat2_r) + 33'(t_r);
  assign a_c   = a_sum[32] ? 31'd0 :
                 (a_sum > 33'(hvd_pkg::ONE_Q)) ? 31'(hvd_pkg::ONE_Q) : a_sum[30:0];

  logic [60:0] sr_n_r   [2][NS+1];
  logic [61:0] sr_res_r [2][NS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_n_r[0][0]   <= {31'(hvd_pkg::ONE_Q) - a_c, 30'd0};
      sr_n_r[1][0]   <= {a_c, 30'd0};
      sr_res_r[0][0] <= '0;
      sr_res_r[1][0] <= '0;
    end
  end

  hvd_pkg::cw_t vx_r [NC+1];
  hvd_pkg::cw_t vy_r [NC+1];
  hvd_pkg::cw_t vz_r [NC+1];

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar j = 0; j < NS; j++) begin : g_dig
      localparam logic [61:0] BITV = 62'(1) << (60 - 2 * j);
      logic [61:0] trial;
      assign trial = sr_res_r[l][j] + BITV;
      always_ff @(posedge clk) begin
        if (adv) begin
          if (62'(sr_n_r[l][j]) >= trial) begin
            sr_n_r[l][j+1]   <= sr_n_r[l][j] - trial[60:0];
            sr_res_r[l][j+1] <= (sr_res_r[l][j] >> 1) + BITV;
          end else begin
            sr_n_r[l][j+1]   <= sr_n_r[l][j];
            sr_res_r[l][j+1] <= sr_res_r[l][j] >> 1;
          end
        end
      end
    end
  end

  logic [30:0] root_x, root_y;
  assign root_x = 31'(sr_res_r[0][NS]) + 31'(62'(sr_n_r[0][NS]) > sr_res_r[0][NS]);
  assign root_y = 31'(sr_res_r[1][NS]) + 31'(62'(sr_n_r[1][NS]) > sr_res_r[1][NS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= $signed(34'(root_x));
      vy_r[0] <= $signed(34'(root_y));
      vz_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_vec
    hvd_pkg::cw_t xs, ys, at;
    assign xs = vx_r[i] >>> i;
    assign ys = vy_r[i] >>> i;
    assign at = $signed(34'(hvd_pkg::ATAN_TURN[i]));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vy_r[i][33] && (vy_r[i] != '0)) begin
          vx_r[i+1] <= vx_r[i] + ys;
          vy_r[i+1] <= vy_r[i] - xs;
          vz_r[i+1] <= vz_r[i] + at;
        end else begin
          vx_r[i+1] <= vx_r[i] - ys;
          vy_r[i+1] <= vy_r[i] + xs;
          vz_r[i+1] <= vz_r[i] - at;
        end
      end
    end
  end

  // Scale: distance = round(R * z * 400 * pi / 2^32).
  logic [30:0]  zt_r;
  logic [53:0]  qp_r;
  logic [62:0]  p00_r, p01_r, p10_r, p11_r;
  logic [99:0]  row0_r, row1_r;
  logic [31:0]  dist_r, dist_nxt;
  logic [126:0] tot;
  logic [33:0]  dq;

  assign tot      = 127'(row0_r) + (127'(row1_r) << 27);
  assign dq       = tot[126:93];
  assign dist_nxt = (dq[33:32] != 2'd0) ? 32'hFFFF_FFFF : dq[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      zt_r   <= vz_r[NC][33] ? 31'd0 :
                (vz_r[NC] > hvd_pkg::QUARTER) ? 31'(hvd_pkg::QUARTER) : vz_r[NC][30:0];
      qp_r   <= 54'(radius_r) * 54'(zt_r);
      p00_r  <= 63'(qp_r[26:0])  * 63'(hvd_pkg::DIST_K[35:0]);
      p01_r  <= 63'(qp_r[26:0])  * 63'(hvd_pkg::DIST_K[71:36]);
      p10_r  <= 63'(qp_r[53:27]) * 63'(hvd_pkg::DIST_K[35:0]);
      p11_r  <= 63'(qp_r[53:27]) * 63'(hvd_pkg::DIST_K[71:36]);
      row0_r <= 100'(p00_r) + (100'(p01_r) << 36) + (100'(1) << 92);
      row1_r <= 100'(p10_r) + (100'(p11_r) << 36);
      dist_r <= dist_nxt;
    end
  end

  assign out_distance_cm = dist_r;

endmodule
`default_nettype wire

@@ sv/hvd_checker.sv @@
// Port-level checker for the haversine distance block, with its bind statement.
`default_nettype none
module hvd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic signed [30:0] in_start_latitude,
  input wire logic signed [31:0] in_start_longitude,
  input wire logic signed [30:0] in_end_latitude,
  input wire logic signed [31:0] in_end_longitude,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [22:0]        cfg_sphere_radius_m,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [31:0]        out_distance_cm
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance_cm))
    else $error("output request changed while stalled");

  // The pipeline accepts a request whenever its output can move.
  a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled although the output can advance");

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  // The radius register takes a write in any cycle.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind haversine_distance_top hvd_checker u_hvd_checker (.*);
`default_nettype wire
